// ===== rtl/srcd_pkg.sv =====
// Shared constants for the scan-line run center detector
`default_nettype none

package srcd_pkg;

  // distance outputs are unsigned fixed point and saturate at the top code
  localparam int unsigned DIST_BITS = 17;
  localparam logic [DIST_BITS-1:0] DIST_MAX = 17'h1FFFF;

  // configuration register indexes
  localparam int unsigned CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] REG_ROBOT_X = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_ROBOT_Y = 2'd1;

endpackage

`default_nettype wire

// ===== rtl/srcd_lane.sv =====
// Serial sum-of-squares and bit-serial integer square root lane
`default_nettype none

module srcd_lane #(
  parameter int unsigned OP_BITS = 13,
  parameter int unsigned SHIFT   = 8,
  localparam int unsigned ROOT_BITS = (2 * OP_BITS + 1 + SHIFT + 1) / 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [OP_BITS-1:0]   op_a_i,
  input  logic [OP_BITS-1:0]   op_b_i,
  output logic                 busy_o,
  output logic [ROOT_BITS-1:0] root_o
);

  localparam int unsigned PROD_BITS = 2 * OP_BITS;
  localparam int unsigned SQ_BITS   = 2 * OP_BITS + 1;
  localparam int unsigned RAD_BITS  = 2 * ROOT_BITS;
  localparam int unsigned REM_BITS  = ROOT_BITS + 2;
  localparam int unsigned MAX_STEPS = (OP_BITS > ROOT_BITS) ? OP_BITS : ROOT_BITS;
  localparam int unsigned CNT_BITS  = $clog2(MAX_STEPS);

  typedef enum logic [1:0] {
    L_IDLE,
    L_SQUARE,
    L_ROOT
  } lane_state_e;

  lane_state_e            state_q, state_d;
  logic [CNT_BITS-1:0]    cnt_q, cnt_d;
  logic [OP_BITS-1:0]     mul_a_q, mul_a_d;
  logic [OP_BITS-1:0]     mul_b_q, mul_b_d;
  logic [PROD_BITS-1:0]   pa_q, pa_d;
  logic [PROD_BITS-1:0]   pb_q, pb_d;
  logic [SQ_BITS-1:0]     acc_q, acc_d;
  logic [RAD_BITS-1:0]    rad_q, rad_d;
  logic [REM_BITS-1:0]    rem_q, rem_d;
  logic [ROOT_BITS-1:0]   root_q, root_d;
  logic [REM_BITS-1:0]    rem_sh;
  logic [REM_BITS-1:0]    trial;

  // one root step: bring down two radicand bits, try to set the next root bit
  assign rem_sh = {rem_q[REM_BITS-3:0], rad_q[RAD_BITS-1 -: 2]};
  assign trial  = {root_q, 2'b01};

  // next-state logic: square phase one multiplier bit a cycle, then one root bit a cycle
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    mul_a_d = mul_a_q;
    mul_b_d = mul_b_q;
    pa_d    = pa_q;
    pb_d    = pb_q;
    acc_d   = acc_q;
    rad_d   = rad_q;
    rem_d   = rem_q;
    root_d  = root_q;
    unique case (state_q)
      L_IDLE: begin
        if (start_i) begin
          mul_a_d = op_a_i;
          mul_b_d = op_b_i;
          pa_d    = PROD_BITS'(op_a_i);
          pb_d    = PROD_BITS'(op_b_i);
          acc_d   = '0;
          cnt_d   = CNT_BITS'(OP_BITS - 1);
          state_d = L_SQUARE;
        end
      end
      L_SQUARE: begin
        acc_d   = acc_q + (mul_a_q[0] ? SQ_BITS'(pa_q) : '0)
                        + (mul_b_q[0] ? SQ_BITS'(pb_q) : '0);
        mul_a_d = mul_a_q >> 1;
        mul_b_d = mul_b_q >> 1;
        pa_d    = pa_q << 1;
        pb_d    = pb_q << 1;
        if (cnt_q == '0) begin
          rad_d   = RAD_BITS'(acc_d) << SHIFT;
          rem_d   = '0;
          root_d  = '0;
          cnt_d   = CNT_BITS'(ROOT_BITS - 1);
          state_d = L_ROOT;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      L_ROOT: begin
        rad_d = rad_q << 2;
        if (rem_sh >= trial) begin
          rem_d  = rem_sh - trial;
          root_d = {root_q[ROOT_BITS-2:0], 1'b1};
        end else begin
          rem_d  = rem_sh;
          root_d = {root_q[ROOT_BITS-2:0], 1'b0};
        end
        if (cnt_q == '0) begin
          state_d = L_IDLE;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      default: begin
        state_d = L_IDLE;
      end
    endcase
  end

  // lane state and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      cnt_q   <= '0;
      mul_a_q <= '0;
      mul_b_q <= '0;
      pa_q    <= '0;
      pb_q    <= '0;
      acc_q   <= '0;
      rad_q   <= '0;
      rem_q   <= '0;
      root_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      mul_a_q <= mul_a_d;
      mul_b_q <= mul_b_d;
      pa_q    <= pa_d;
      pb_q    <= pb_d;
      acc_q   <= acc_d;
      rad_q   <= rad_d;
      rem_q   <= rem_d;
      root_q  <= root_d;
    end
  end

  assign busy_o = (state_q != L_IDLE);
  assign root_o = root_q;

endmodule

`default_nettype wire

// ===== rtl/scanline_run_center_detector_unit.sv =====
// A pixel that does not close a reportable run is taken without stalling the input.
// A pixel that closes a run holds the input stalled while both lanes compute: COORD_BITS+1
// square steps and COORD_BITS+FRAC_BITS+2 root steps in the width lane, the longer lane,
// and then the output register is loaded once it is free.
// The input is taken again while the finished result waits in the output register.
// Reset (asynchronous, active low) clears run state, robot position and output valid.
`default_nettype none

module scanline_run_center_detector_unit #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned FRAC_BITS  = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [srcd_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [COORD_BITS-1:0]             cfg_data_i,
  // pixel requests
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [COORD_BITS-1:0]             pos_x_i,
  input  logic [COORD_BITS-1:0]             pos_y_i,
  input  logic                              is_line_i,
  input  logic                              last_pixel_i,
  // run reports
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [COORD_BITS-1:0]             start_x_o,
  output logic [COORD_BITS-1:0]             start_y_o,
  output logic [COORD_BITS-1:0]             end_x_o,
  output logic [COORD_BITS-1:0]             end_y_o,
  output logic [COORD_BITS:0]               center_x_half_o,
  output logic [COORD_BITS:0]               center_y_half_o,
  output logic [srcd_pkg::DIST_BITS-1:0]    run_width_o,
  output logic [srcd_pkg::DIST_BITS-1:0]    robot_distance_o
);

  import srcd_pkg::*;

  localparam int unsigned OP_BITS   = COORD_BITS + 1;
  localparam int unsigned W_SHIFT   = 2 * FRAC_BITS;
  localparam int unsigned D_SHIFT   = 2 * FRAC_BITS - 2;
  localparam int unsigned W_ROOT    = (2 * OP_BITS + 1 + W_SHIFT + 1) / 2;
  localparam int unsigned D_ROOT    = (2 * OP_BITS + 1 + D_SHIFT + 1) / 2;
  localparam int unsigned W_CMP     = (W_ROOT + 1 > DIST_BITS) ? W_ROOT + 1 : DIST_BITS;
  localparam int unsigned D_CMP     = (D_ROOT > DIST_BITS) ? D_ROOT : DIST_BITS;
  localparam int unsigned ONE_FRAC  = 1 << FRAC_BITS;

  typedef enum logic {
    T_IDLE,
    T_CALC
  } top_state_e;

  top_state_e              state_q, state_d;
  logic                    out_valid_q, out_valid_d;

  logic                    inside_q;
  logic [COORD_BITS-1:0]   first_x_q, first_y_q, latest_x_q, latest_y_q;
  logic [COORD_BITS-1:0]   robot_x_q, robot_y_q;

  logic [COORD_BITS-1:0]   pend_sx_q, pend_sy_q, pend_ex_q, pend_ey_q;
  logic [COORD_BITS:0]     pend_cx_q, pend_cy_q;

  logic [COORD_BITS-1:0]   out_sx_q, out_sy_q, out_ex_q, out_ey_q;
  logic [COORD_BITS:0]     out_cx_q, out_cy_q;
  logic [DIST_BITS-1:0]    out_width_q, out_dist_q;

  logic                    in_acc;
  logic                    emit;
  logic                    finish;
  logic                    w_busy, d_busy;
  logic [W_ROOT-1:0]       w_root;
  logic [D_ROOT-1:0]       d_root;
  logic [COORD_BITS-1:0]   dx, dy;
  logic [COORD_BITS:0]     cx_sum, cy_sum, rob_x2, rob_y2, hx, hy;
  logic [W_CMP-1:0]        width_sum;
  logic [DIST_BITS-1:0]    width_sat, dist_sat;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != T_IDLE);

  // a non-line pixel closes the open run; single-point runs report nothing
  assign emit = in_acc && !is_line_i && inside_q &&
                ((first_x_q != latest_x_q) || (first_y_q != latest_y_q));

  // endpoint offsets and center to robot offsets in half pixels
  assign dx     = (first_x_q >= latest_x_q) ? first_x_q - latest_x_q : latest_x_q - first_x_q;
  assign dy     = (first_y_q >= latest_y_q) ? first_y_q - latest_y_q : latest_y_q - first_y_q;
  assign cx_sum = {1'b0, first_x_q} + {1'b0, latest_x_q};
  assign cy_sum = {1'b0, first_y_q} + {1'b0, latest_y_q};
  assign rob_x2 = {robot_x_q, 1'b0};
  assign rob_y2 = {robot_y_q, 1'b0};
  assign hx     = (cx_sum >= rob_x2) ? cx_sum - rob_x2 : rob_x2 - cx_sum;
  assign hy     = (cy_sum >= rob_y2) ? cy_sum - rob_y2 : rob_y2 - cy_sum;

  // width lane: sqrt((dx^2 + dy^2) * 4^F)
  srcd_lane #(
    .OP_BITS (OP_BITS),
    .SHIFT   (W_SHIFT)
  ) u_width_lane (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (emit),
    .op_a_i  (OP_BITS'(dx)),
    .op_b_i  (OP_BITS'(dy)),
    .busy_o  (w_busy),
    .root_o  (w_root)
  );

  // distance lane: sqrt((hx^2 + hy^2) * 4^F / 4)
  srcd_lane #(
    .OP_BITS (OP_BITS),
    .SHIFT   (D_SHIFT)
  ) u_dist_lane (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (emit),
    .op_a_i  (hx),
    .op_b_i  (hy),
    .busy_o  (d_busy),
    .root_o  (d_root)
  );

  // add one pixel to the width and saturate both distances
  assign width_sum = W_CMP'(w_root) + W_CMP'(ONE_FRAC);
  assign width_sat = (width_sum > W_CMP'(DIST_MAX)) ? DIST_MAX : DIST_BITS'(width_sum);
  assign dist_sat  = (D_CMP'(d_root) > D_CMP'(DIST_MAX)) ? DIST_MAX : DIST_BITS'(d_root);

  // both lanes done and output register free or emptying this cycle
  assign finish = (state_q == T_CALC) && !w_busy && !d_busy &&
                  (!out_valid_q || !out_stall_i);

  // sequencer next state
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      T_IDLE: begin
        if (emit) begin
          state_d = T_CALC;
        end
      end
      T_CALC: begin
        if (finish) begin
          out_valid_d = 1'b1;
          state_d     = T_IDLE;
        end
      end
      default: begin
        state_d = T_IDLE;
      end
    endcase
  end

  // sequencer state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // run tracking; the last pixel of a line clears it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q   <= 1'b0;
      first_x_q  <= '0;
      first_y_q  <= '0;
      latest_x_q <= '0;
      latest_y_q <= '0;
    end else if (in_acc) begin
      if (last_pixel_i) begin
        inside_q   <= 1'b0;
        first_x_q  <= '0;
        first_y_q  <= '0;
        latest_x_q <= '0;
        latest_y_q <= '0;
      end else begin
        inside_q <= is_line_i;
        if (is_line_i) begin
          latest_x_q <= pos_x_i;
          latest_y_q <= pos_y_i;
          if (!inside_q) begin
            first_x_q <= pos_x_i;
            first_y_q <= pos_y_i;
          end
        end
      end
    end
  end

  // robot position registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      robot_x_q <= '0;
      robot_y_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_ROBOT_X: robot_x_q <= cfg_data_i;
        REG_ROBOT_Y: robot_y_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // endpoints of the run under calculation
  always_ff @(posedge clk_i) begin
    if (emit) begin
      pend_sx_q <= first_x_q;
      pend_sy_q <= first_y_q;
      pend_ex_q <= latest_x_q;
      pend_ey_q <= latest_y_q;
      pend_cx_q <= cx_sum;
      pend_cy_q <= cy_sum;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_sx_q    <= pend_sx_q;
      out_sy_q    <= pend_sy_q;
      out_ex_q    <= pend_ex_q;
      out_ey_q    <= pend_ey_q;
      out_cx_q    <= pend_cx_q;
      out_cy_q    <= pend_cy_q;
      out_width_q <= width_sat;
      out_dist_q  <= dist_sat;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign start_x_o        = out_sx_q;
  assign start_y_o        = out_sy_q;
  assign end_x_o          = out_ex_q;
  assign end_y_o          = out_ey_q;
  assign center_x_half_o  = out_cx_q;
  assign center_y_half_o  = out_cy_q;
  assign run_width_o      = out_width_q;
  assign robot_distance_o = out_dist_q;

endmodule

`default_nettype wire

// ===== rtl/srcd_checker.sv =====
// Port-level checks for the scan-line run center detector, with its bind
`default_nettype none

module srcd_checker #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned FRAC_BITS  = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_stall_o,
  input  logic                           out_valid_o,
  input  logic                           out_stall_i,
  input  logic [COORD_BITS-1:0]          start_x_o,
  input  logic [COORD_BITS-1:0]          start_y_o,
  input  logic [COORD_BITS-1:0]          end_x_o,
  input  logic [COORD_BITS-1:0]          end_y_o,
  input  logic [COORD_BITS:0]            center_x_half_o,
  input  logic [COORD_BITS:0]            center_y_half_o,
  input  logic [srcd_pkg::DIST_BITS-1:0] run_width_o
);

  import srcd_pkg::*;

  localparam logic [DIST_BITS-1:0] MIN_WIDTH = DIST_BITS'(1 << FRAC_BITS);

  // a stalled report stays and keeps its width
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(run_width_o))
    else $error("stalled report changed");

  // a new report only appears at the end of a calculation that held the input
  a_rise_after_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("report appeared without a calculation");

  // width is never below one pixel
  a_width_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> run_width_o >= MIN_WIDTH)
    else $error("run width below one pixel");

  // center equals start plus end
  a_center: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (center_x_half_o == {1'b0, start_x_o} + {1'b0, end_x_o}) &&
                    (center_y_half_o == {1'b0, start_y_o} + {1'b0, end_y_o}))
    else $error("center does not match endpoints");

  // single-point runs are never reported
  a_not_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (start_x_o != end_x_o) || (start_y_o != end_y_o))
    else $error("single-point run reported");

endmodule

bind scanline_run_center_detector_unit srcd_checker #(
  .COORD_BITS (COORD_BITS),
  .FRAC_BITS  (FRAC_BITS)
) u_srcd_checker (.*);

`default_nettype wire

// ===== test/scanline_run_center_detector_unit_tb.sv =====
// Testbench for the scan-line run center detector: random search lines checked by a predictor
`timescale 1ns / 100ps

module scanline_run_center_detector_unit_tb;
  import srcd_pkg::*;

  localparam int unsigned COORD_BITS = 12;
  localparam int unsigned FRAC_BITS  = 4;
  // wait after a drain that covers the calculation of a closing pixel, with margin
  localparam int unsigned SETTLE_CYCLES = 2*COORD_BITS + FRAC_BITS + 12;
  localparam int unsigned IDLE_LIMIT = 5000;
  localparam int unsigned PIXELS_PER_PHASE = 340;
  localparam int unsigned DRAIN_EVERY = 120;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   line;
    logic   last;
  } pixel_t;

  typedef struct packed {
    coord_t                sx;
    coord_t                sy;
    coord_t                ex;
    coord_t                ey;
    logic [COORD_BITS:0]   cx;
    logic [COORD_BITS:0]   cy;
    logic [DIST_BITS-1:0]  width;
    logic [DIST_BITS-1:0]  distance;
  } run_report_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  coord_t                  cfg_data  = '0;

  logic   in_valid   = 1'b0;
  logic   in_stall;
  coord_t pos_x      = '0;
  coord_t pos_y      = '0;
  logic   is_line    = 1'b0;
  logic   last_pixel = 1'b0;

  logic                  out_valid;
  logic                  out_stall = 1'b0;
  coord_t                start_x, start_y, end_x, end_y;
  logic [COORD_BITS:0]   center_x_half, center_y_half;
  logic [DIST_BITS-1:0]  run_width, robot_distance;

  scanline_run_center_detector_unit #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .pos_x_i         (pos_x),
    .pos_y_i         (pos_y),
    .is_line_i       (is_line),
    .last_pixel_i    (last_pixel),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .start_x_o       (start_x),
    .start_y_o       (start_y),
    .end_x_o         (end_x),
    .end_y_o         (end_y),
    .center_x_half_o (center_x_half),
    .center_y_half_o (center_y_half),
    .run_width_o     (run_width),
    .robot_distance_o(robot_distance)
  );

  // pending pixel requests and expected run reports
  pixel_t      pixel_q[$];
  run_report_t run_q[$];
  int unsigned fail_cnt = 0;

  // predictor copy of run tracking and robot position
  logic   run_open    = 1'b0;
  coord_t run_first_x = '0;
  coord_t run_first_y = '0;
  coord_t run_last_x  = '0;
  coord_t run_last_y  = '0;
  coord_t robot_col   = '0;
  coord_t robot_row   = '0;

  // driver and monitor locals
  int unsigned gap_left   = 0;
  int unsigned burst_left = 0;
  pixel_t      next_pix;
  pixel_t      taken_pix;
  run_report_t want;

  // receiver stall pattern state
  int unsigned stall_mode      = 0;
  int unsigned stall_mode_left = 0;
  int unsigned stall_hold      = 0;

  int unsigned idle_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // truncated integer square root
  function automatic logic [63:0] isqrt_floor(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] bitv;
    rem  = v;
    root = '0;
    bitv = 64'h1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem  = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic logic [63:0] abs_diff(input logic [63:0] a, input logic [63:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  function automatic logic [DIST_BITS-1:0] clamp_dist(input logic [63:0] v);
    return (v > 64'(DIST_MAX)) ? DIST_MAX : v[DIST_BITS-1:0];
  endfunction

  // update run tracking for one accepted pixel and queue any run report it closes
  task automatic track_pixel(input pixel_t p);
    logic [63:0] cxh, cyh, dx, dy, hx, hy, rx2, ry2, wsq, dsq;
    run_report_t rep;
    if (p.line) begin
      run_last_x = p.x;
      run_last_y = p.y;
      if (!run_open) begin
        run_first_x = p.x;
        run_first_y = p.y;
      end
    end else if (run_open && (run_first_x != run_last_x || run_first_y != run_last_y)) begin
      cxh = 64'(run_first_x) + 64'(run_last_x);
      cyh = 64'(run_first_y) + 64'(run_last_y);
      dx  = abs_diff(64'(run_first_x), 64'(run_last_x));
      dy  = abs_diff(64'(run_first_y), 64'(run_last_y));
      wsq = (dx * dx + dy * dy) << (2 * FRAC_BITS);
      rx2 = 64'(robot_col) << 1;
      ry2 = 64'(robot_row) << 1;
      // offsets are in half pixels, so two fraction bits fewer
      hx  = abs_diff(cxh, rx2);
      hy  = abs_diff(cyh, ry2);
      dsq = (hx * hx + hy * hy) << (2 * FRAC_BITS - 2);
      rep.sx       = run_first_x;
      rep.sy       = run_first_y;
      rep.ex       = run_last_x;
      rep.ey       = run_last_y;
      rep.cx       = cxh[COORD_BITS:0];
      rep.cy       = cyh[COORD_BITS:0];
      rep.width    = clamp_dist(isqrt_floor(wsq) + (64'd1 << FRAC_BITS));
      rep.distance = clamp_dist(isqrt_floor(dsq));
      run_q = {run_q, rep};
    end
    run_open = p.line;
    // end of search line clears the run
    if (p.last) begin
      run_open    = 1'b0;
      run_first_x = '0;
      run_first_y = '0;
      run_last_x  = '0;
      run_last_y  = '0;
    end
  endtask

  task automatic check_field(input string name, input logic [DIST_BITS-1:0] exp_v,
                             input logic [DIST_BITS-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      fail_cnt++;
    end
  endtask

  task automatic push_pix(input coord_t x, input coord_t y, input logic line, input logic last);
    pixel_t p;
    p.x    = x;
    p.y    = y;
    p.line = line;
    p.last = last;
    pixel_q = {pixel_q, p};
  endtask

  // one well-formed search line: a walk with alternating line and background segments
  task automatic push_scan_line(output int unsigned len);
    coord_t      x, y;
    int          step_x, step_y;
    logic        line_now;
    int unsigned seg_left;
    int unsigned i;
    len      = $urandom_range(2, 40);
    x        = coord_t'($urandom);
    y        = coord_t'($urandom);
    step_x   = int'($urandom_range(0, 2)) - 1;
    step_y   = int'($urandom_range(0, 2)) - 1;
    line_now = 1'($urandom_range(0, 1));
    seg_left = $urandom_range(1, 8);
    for (i = 0; i < len; i++) begin
      push_pix(x, y, line_now, i == len - 1);
      if ($urandom_range(0, 15) == 0) begin
        x = coord_t'($urandom);
        y = coord_t'($urandom);
      end else begin
        x = coord_t'(int'(x) + step_x);
        y = coord_t'(int'(y) + step_y);
      end
      seg_left = seg_left - 1;
      if (seg_left == 0) begin
        line_now = !line_now;
        seg_left = $urandom_range(1, 8);
      end
    end
  endtask

  // wait until the sender is empty and every expected report has come
  task automatic drain();
    @(negedge clk_i);
    while (pixel_q.size() != 0 || in_valid || run_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // mostly scan lines, some stray pixels, with full drains in between
  task automatic push_random(input int unsigned count);
    int unsigned pushed, since_drain, n;
    pushed      = 0;
    since_drain = 0;
    @(negedge clk_i);
    while (pushed < count) begin
      if ($urandom_range(0, 9) == 0) begin
        push_pix(coord_t'($urandom), coord_t'($urandom), 1'($urandom_range(0, 1)),
                 $urandom_range(0, 7) == 0);
        n = 1;
      end else begin
        push_scan_line(n);
      end
      pushed      = pushed + n;
      since_drain = since_drain + n;
      if (since_drain >= DRAIN_EVERY) begin
        drain();
        since_drain = 0;
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input coord_t value);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    if (idx == REG_ROBOT_X) begin
      robot_col = value;
    end else if (idx == REG_ROBOT_Y) begin
      robot_row = value;
    end
    cfg_valid <= 1'b0;
  endtask

  // pixel driver: bursts with random gaps, predicts on every accepted request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid   <= 1'b0;
      pos_x      <= '0;
      pos_y      <= '0;
      is_line    <= 1'b0;
      last_pixel <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        taken_pix.x    = pos_x;
        taken_pix.y    = pos_y;
        taken_pix.line = is_line;
        taken_pix.last = last_pixel;
        track_pixel(taken_pix);
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          in_valid <= 1'b0;
        end else if (pixel_q.size() > 0) begin
          next_pix = pixel_q.pop_front();
          in_valid   <= 1'b1;
          pos_x      <= next_pix.x;
          pos_y      <= next_pix.y;
          is_line    <= next_pix.line;
          last_pixel <= next_pix.last;
          if (burst_left > 0) begin
            burst_left = burst_left - 1;
          end else begin
            burst_left = $urandom_range(0, 39);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall: free running, random, or long holds, switching every so often
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_mode_left == 0) begin
        stall_mode      = $urandom_range(0, 2);
        stall_mode_left = $urandom_range(20, 200);
      end else begin
        stall_mode_left = stall_mode_left - 1;
      end
      case (stall_mode)
        0: begin
          out_stall <= 1'b0;
        end
        1: begin
          out_stall <= ($urandom_range(0, 2) == 0);
        end
        default: begin
          if (stall_hold > 0) begin
            stall_hold = stall_hold - 1;
            out_stall <= 1'b1;
          end else begin
            stall_hold = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 25) : 0;
            out_stall <= 1'b0;
          end
        end
      endcase
    end
  end

  // report monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      if (run_q.size() == 0) begin
        $display("%0t: unexpected run report, start (%0d,%0d) end (%0d,%0d)",
                 $time, start_x, start_y, end_x, end_y);
        fail_cnt++;
      end else begin
        want = run_q.pop_front();
        check_field("start_x", DIST_BITS'(want.sx), DIST_BITS'(start_x));
        check_field("start_y", DIST_BITS'(want.sy), DIST_BITS'(start_y));
        check_field("end_x", DIST_BITS'(want.ex), DIST_BITS'(end_x));
        check_field("end_y", DIST_BITS'(want.ey), DIST_BITS'(end_y));
        check_field("center_x_half", DIST_BITS'(want.cx), DIST_BITS'(center_x_half));
        check_field("center_y_half", DIST_BITS'(want.cy), DIST_BITS'(center_y_half));
        check_field("run_width", want.width, run_width);
        check_field("robot_distance", want.distance, robot_distance);
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles = idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: timeout, no handshake for %0d cycles", $time, idle_cycles);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // stimulus sequence
  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // robot at reset position: extremes and special cases
    @(negedge clk_i);
    push_pix(12'd0, 12'd0, 1'b1, 1'b0);
    push_pix(12'd4095, 12'd4095, 1'b1, 1'b0);
    push_pix(12'd100, 12'd200, 1'b0, 1'b0);
    push_pix(12'd4095, 12'd0, 1'b1, 1'b0);
    push_pix(12'd0, 12'd4095, 1'b1, 1'b0);
    push_pix(12'd1, 12'd1, 1'b0, 1'b0);
    // single pixel run
    push_pix(12'd10, 12'd10, 1'b1, 1'b0);
    push_pix(12'd11, 12'd11, 1'b0, 1'b0);
    // one position repeated
    push_pix(12'd7, 12'd7, 1'b1, 1'b0);
    push_pix(12'd7, 12'd7, 1'b1, 1'b0);
    push_pix(12'd0, 12'd0, 1'b0, 1'b0);
    // run still open at the last pixel is dropped
    push_pix(12'd1, 12'd2, 1'b1, 1'b0);
    push_pix(12'd3, 12'd4, 1'b1, 1'b1);
    push_pix(12'd9, 12'd9, 1'b0, 1'b0);
    // run closed by the last pixel
    push_pix(12'd20, 12'd30, 1'b1, 1'b0);
    push_pix(12'd25, 12'd30, 1'b1, 1'b0);
    push_pix(12'd26, 12'd30, 1'b0, 1'b1);
    // diagonal run across the mid-range bit boundary
    push_pix(12'd5, 12'd5, 1'b0, 1'b0);
    push_pix(12'd2048, 12'd2047, 1'b1, 1'b0);
    push_pix(12'd2047, 12'd2048, 1'b1, 1'b0);
    push_pix(12'd2046, 12'd2049, 1'b1, 1'b0);
    push_pix(12'd0, 12'd0, 1'b0, 1'b1);
    push_random(PIXELS_PER_PHASE);
    settle();

    // robot at far corner
    write_reg(REG_ROBOT_X, 12'd4095);
    write_reg(REG_ROBOT_Y, 12'd4095);
    push_random(PIXELS_PER_PHASE);
    settle();

    write_reg(REG_ROBOT_X, 12'd0);
    write_reg(REG_ROBOT_Y, 12'd4095);
    push_random(PIXELS_PER_PHASE);
    settle();

    write_reg(REG_ROBOT_X, coord_t'($urandom));
    write_reg(REG_ROBOT_Y, coord_t'($urandom));
    push_random(PIXELS_PER_PHASE);
    settle();

    write_reg(REG_ROBOT_X, 12'd4095);
    write_reg(REG_ROBOT_Y, 12'd0);
    push_random(PIXELS_PER_PHASE);
    settle();

    if (fail_cnt == 0 && run_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (run_q.size() != 0) begin
        $display("%0t: %0d run reports never arrived", $time, run_q.size());
      end
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
